[src/dbws_pkg.sv]
package dbws_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_APPEND       = 3'd0;
  localparam kind_t KIND_WRITE        = 3'd1;
  localparam kind_t KIND_READ         = 3'd2;
  localparam kind_t KIND_SWAP_FORCED  = 3'd3;
  localparam kind_t KIND_SWAP_GUARDED = 3'd4;
  localparam kind_t KIND_SET_CURSOR   = 3'd5;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd256;
  localparam logic [PERIOD_W-1:0] COUNT_MAX    = 16'hFFFF;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [PERIOD_W-1:0] period_t;

  // Reduces a position modulo the bank size by conditional subtraction of
  // shifted copies of the bank size, most significant first.
  function automatic index_t pos_mod(input index_t pos, input int unsigned bank_words);
    logic [31:0] r;
    logic [31:0] step;
    r = 32'(pos);
    for (int s = INDEX_W - 1; s >= 0; s--) begin
      step = 32'(bank_words) << s;
      if (step <= 32'((1 << INDEX_W) - 1) && r >= step) begin
        r = r - step;
      end
    end
    return index_t'(r);
  endfunction

endpackage

[src/double_bank_word_store_unit.sv]
// A word is registered into stage 1, then into stage 2, which drives the outputs.
// Throughput: one word per cycle while neither out_stall nor the clearing pass stalls the input.
// Reset: rst is synchronous; after it the store is cleared one word per
// cycle over all 2*BANK_WORDS words, during which in_stall stays high.
// Bank select, write cursor, read count and swap period reset at once.
module double_bank_word_store_unit #(
  parameter int unsigned BANK_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  dbws_pkg::period_t cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  dbws_pkg::kind_t   kind,
  input  dbws_pkg::word_t   value,
  input  dbws_pkg::index_t  index,
  input  logic              hold,
  output logic              out_valid,
  input  logic              out_stall,
  output dbws_pkg::word_t   read_data,
  output logic              refused,
  output logic              active_bank
);
  import dbws_pkg::*;

  localparam int unsigned CW    = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
  localparam int unsigned DEPTH = 2 * BANK_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);

  word_t mem [DEPTH];
  word_t mem_q;

  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  logic    s1_valid;
  kind_t   s1_kind;
  word_t   s1_value;
  index_t  s1_index;
  logic    s1_hold;

  logic    s2_valid;
  logic    s2_is_read;
  logic    s2_refused;

  logic    bank;
  logic    bank_next;
  logic [CW-1:0] cursor;
  logic [CW-1:0] cursor_next;
  period_t read_count;
  period_t read_count_next;
  period_t swap_period;

  logic    s2_free;
  logic    s1_fire;
  period_t count_inc;
  logic    refused_next;
  logic    do_write;
  logic    do_read;
  logic [CW-1:0] pos;
  logic [AW-1:0] item_addr;
  logic [AW-1:0] wr_addr;

  assign s2_free  = !s2_valid || !out_stall;
  assign s1_fire  = s1_valid && s2_free;
  assign in_stall = clr_busy || (s1_valid && !s2_free);

  assign count_inc = (read_count < COUNT_MAX) ? read_count + 1'b1 : read_count;

  always_comb begin
    bank_next       = bank;
    cursor_next     = cursor;
    read_count_next = read_count;
    refused_next    = 1'b0;
    do_write        = 1'b0;
    do_read         = 1'b0;
    pos             = CW'(pos_mod(s1_index, BANK_WORDS));
    unique case (s1_kind)
      KIND_APPEND: begin
        do_write    = 1'b1;
        pos         = cursor;
        cursor_next = (cursor == CW'(BANK_WORDS - 1)) ? '0 : cursor + 1'b1;
      end
      KIND_WRITE: begin
        do_write = 1'b1;
      end
      KIND_READ: begin
        do_read         = 1'b1;
        read_count_next = count_inc;
        if (count_inc >= swap_period) begin
          if (s1_hold) begin
            refused_next = 1'b1;
          end else begin
            bank_next       = !bank;
            read_count_next = '0;
          end
        end
      end
      KIND_SWAP_FORCED: begin
        bank_next = !bank;
      end
      KIND_SWAP_GUARDED: begin
        if (s1_hold) begin
          refused_next = 1'b1;
        end else begin
          bank_next = !bank;
        end
      end
      KIND_SET_CURSOR: begin
        cursor_next = CW'(pos_mod(s1_index, BANK_WORDS));
      end
      default: begin
      end
    endcase
    item_addr = AW'(pos) + (bank_next ? AW'(BANK_WORDS) : AW'(0));
  end

  assign wr_addr = clr_busy ? clr_addr : item_addr;

  always_ff @(posedge clk) begin
    if (clr_busy || (s1_fire && do_write)) begin
      mem[wr_addr] <= clr_busy ? '0 : s1_value;
    end
    if (s1_fire && do_read) begin
      mem_q <= mem[item_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_period <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      swap_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      bank       <= 1'b0;
      cursor     <= '0;
      read_count <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_fire;
      end
      if (s1_fire) begin
        bank       <= bank_next;
        cursor     <= cursor_next;
        read_count <= read_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind  <= kind;
      s1_value <= value;
      s1_index <= index;
      s1_hold  <= hold;
    end
    if (s1_fire) begin
      s2_is_read <= do_read;
      s2_refused <= refused_next;
    end
  end

  assign out_valid   = s2_valid;
  assign read_data   = s2_is_read ? mem_q : '0;
  assign refused     = s2_refused;
  assign active_bank = bank;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s1_valid && !s2_valid)
    else $error("item in flight during clearing pass");

  a_auto_swap_clears_count: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_kind == KIND_READ && !s1_hold && count_inc >= swap_period)
      |=> read_count == '0 && bank != $past(bank))
    else $error("automatic swap did not clear count or flip bank");

  a_guarded_swap: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_kind == KIND_SWAP_GUARDED)
      |=> (bank == $past(bank)) == $past(s1_hold) && refused == $past(s1_hold))
    else $error("guarded swap ignored hold");

endmodule

[tb/double_bank_word_store_unit_tb.sv]
module double_bank_word_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbws_pkg::*;

  localparam kind_t KIND_SPARE_LO = 3'd6;
  localparam kind_t KIND_SPARE_HI = 3'd7;
  localparam int unsigned STORE_WORDS = 2048;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASE_WORDS = 75;

  typedef struct packed {
    word_t data;
    logic  refused;
    logic  bank;
  } reply_t;

  typedef struct packed {
    kind_t  kind;
    word_t  value;
    index_t index;
    logic   hold;
    logic   typed;
    reply_t reply;
  } row_t;

  logic    clk;
  logic    rst;
  logic    cfg_wr_en;
  period_t cfg_wr_data;
  logic    in_valid;
  logic    in_stall;
  kind_t   kind;
  word_t   value;
  index_t  index;
  logic    hold;
  logic    out_valid;
  logic    out_stall;
  word_t   read_data;
  logic    refused;
  logic    active_bank;

  word_t   store_model [STORE_WORDS];
  logic    bank_model;
  index_t  cursor_model;
  period_t count_model;
  period_t period_model;

  reply_t  store_replies [$];
  reply_t  want;
  reply_t  got;
  int      mismatches;
  int      cycles;
  int      calm_left;
  int      stall_left;
  int      open_left;
  int      stall_pick;
  period_t phase_plan [7];

  row_t directed_rows [22] = '{
    '{KIND_READ,         32'h0,        10'd0,    1'b0, 1'b1, '{32'h0,        1'b0, 1'b0}},
    '{KIND_READ,         32'h0,        10'd1023, 1'b0, 1'b1, '{32'h0,        1'b0, 1'b0}},
    '{KIND_APPEND,       32'hFFFFFFFF, 10'd0,    1'b0, 1'b1, '{32'h0,        1'b0, 1'b0}},
    '{KIND_APPEND,       32'h0,        10'd1023, 1'b1, 1'b1, '{32'h0,        1'b0, 1'b0}},
    '{KIND_WRITE,        32'hA5A5A5A5, 10'd1023, 1'b0, 1'b1, '{32'h0,        1'b0, 1'b0}},
    '{KIND_READ,         32'h0,        10'd0,    1'b0, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b0}},
    '{KIND_READ,         32'h0,        10'd1023, 1'b1, 1'b1, '{32'hA5A5A5A5, 1'b0, 1'b0}},
    '{KIND_SWAP_GUARDED, 32'h0,        10'd0,    1'b1, 1'b1, '{32'h0,        1'b1, 1'b0}},
    '{KIND_SWAP_GUARDED, 32'h0,        10'd0,    1'b0, 1'b1, '{32'h0,        1'b0, 1'b1}},
    '{KIND_READ,         32'h0,        10'd0,    1'b0, 1'b1, '{32'h0,        1'b0, 1'b1}},
    '{KIND_SET_CURSOR,   32'h0,        10'd1023, 1'b0, 1'b1, '{32'h0,        1'b0, 1'b1}},
    '{KIND_APPEND,       32'h12345678, 10'd0,    1'b0, 1'b1, '{32'h0,        1'b0, 1'b1}},
    '{KIND_APPEND,       32'h5A5A5A5A, 10'd0,    1'b0, 1'b1, '{32'h0,        1'b0, 1'b1}},
    '{KIND_READ,         32'h0,        10'd1023, 1'b0, 1'b1, '{32'h12345678, 1'b0, 1'b1}},
    '{KIND_READ,         32'h0,        10'd0,    1'b0, 1'b1, '{32'h5A5A5A5A, 1'b0, 1'b1}},
    '{KIND_SPARE_LO,     32'hFFFFFFFF, 10'd1023, 1'b1, 1'b1, '{32'h0,        1'b0, 1'b1}},
    '{KIND_SPARE_HI,     32'hFFFFFFFF, 10'd1023, 1'b1, 1'b1, '{32'h0,        1'b0, 1'b1}},
    '{KIND_SWAP_FORCED,  32'h0,        10'd0,    1'b1, 1'b1, '{32'h0,        1'b0, 1'b0}},
    '{KIND_READ,         32'h0,        10'd1023, 1'b0, 1'b1, '{32'hA5A5A5A5, 1'b0, 1'b0}},
    '{KIND_SET_CURSOR,   32'h0,        10'h2AA,  1'b0, 1'b0, '0},
    '{KIND_APPEND,       32'h0F0F0F0F, 10'h155,  1'b0, 1'b0, '0},
    '{KIND_READ,         32'h0,        10'h2AA,  1'b1, 1'b0, '0}
  };

  double_bank_word_store_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .value       (value),
    .index       (index),
    .hold        (hold),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .refused     (refused),
    .active_bank (active_bank)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic reply_t apply_store_op(kind_t k, word_t v, index_t idx, logic h);
    reply_t r;
    r = '0;
    case (k)
      KIND_APPEND: begin
        store_model[{bank_model, cursor_model}] = v;
        cursor_model = cursor_model + 1'b1;
      end
      KIND_WRITE: begin
        store_model[{bank_model, idx}] = v;
      end
      KIND_READ: begin
        if (count_model != COUNT_MAX) begin
          count_model = count_model + 1'b1;
        end
        if (count_model >= period_model) begin
          if (h) begin
            r.refused = 1'b1;
          end else begin
            bank_model = ~bank_model;
            count_model = '0;
          end
        end
        r.data = store_model[{bank_model, idx}];
      end
      KIND_SWAP_FORCED: begin
        bank_model = ~bank_model;
      end
      KIND_SWAP_GUARDED: begin
        if (h) begin
          r.refused = 1'b1;
        end else begin
          bank_model = ~bank_model;
        end
      end
      KIND_SET_CURSOR: begin
        cursor_model = idx;
      end
      default: begin
      end
    endcase
    r.bank = bank_model;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 60);
    end
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 50);
  endfunction

  function automatic index_t pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return index_t'($urandom_range(0, 15));
    end else if (r < 85) begin
      return index_t'($urandom_range(1008, 1023));
    end
    return index_t'($urandom_range(0, 1023));
  endfunction

  function automatic word_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return word_t'($urandom());
  endfunction

  task automatic send_word(kind_t k, word_t v, index_t idx, logic h, logic typed,
                           reply_t typed_reply);
    reply_t r;
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind <= k;
    value <= v;
    index <= idx;
    hold <= h;
    in_valid <= 1'b1;
    r = apply_store_op(k, v, idx, h);
    store_replies.push_back(typed ? typed_reply : r);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_and_park();
    @(negedge clk);
    in_valid <= 1'b0;
    while (store_replies.size() != 0) @(negedge clk);
  endtask

  task automatic set_swap_period(period_t p);
    drain_and_park();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    period_model = p;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random_phase(int n);
    int done;
    int pick;
    kind_t k;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        k = KIND_READ;
      end else if (pick < 50) begin
        k = KIND_APPEND;
      end else if (pick < 63) begin
        k = KIND_WRITE;
      end else if (pick < 69) begin
        k = KIND_SWAP_FORCED;
      end else if (pick < 79) begin
        k = KIND_SWAP_GUARDED;
      end else if (pick < 87) begin
        k = KIND_SET_CURSOR;
      end else if (pick < 91) begin
        k = ($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
      end else begin
        k = KIND_READ;
      end
      send_word(k, pick_value(), pick_index(), ($urandom_range(0, 2) == 0), 1'b0, '0);
      if (k != KIND_SPARE_LO && k != KIND_SPARE_HI) begin
        done++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0 && open_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 3) begin
        open_left = $urandom_range(30, 100);
      end else if (stall_pick < 60) begin
        stall_left = 0;
      end else if (stall_pick < 90) begin
        stall_left = $urandom_range(1, 3);
      end else if (stall_pick < 98) begin
        stall_left = $urandom_range(4, 10);
      end else begin
        stall_left = $urandom_range(15, 40);
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (open_left > 0) begin
        open_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = '{read_data, refused, active_bank};
      if (store_replies.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected word: data %h refused %b bank %b", read_data, refused,
                   active_bank);
        end
        mismatches++;
      end else begin
        want = store_replies.pop_front();
        if (got.data !== want.data || got.refused !== want.refused ||
            got.bank !== want.bank) begin
          if (mismatches < 10) begin
            $display("mismatch: expected data %h refused %b bank %b,",
                     want.data, want.refused, want.bank,
                     " got data %h refused %b bank %b",
                     got.data, got.refused, got.bank);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    kind = KIND_APPEND;
    value = '0;
    index = '0;
    hold = 1'b0;
    out_stall = 1'b0;
    mismatches = 0;
    cycles = 0;
    calm_left = 0;
    stall_left = 0;
    open_left = 0;
    for (int i = 0; i < STORE_WORDS; i++) begin
      store_model[i] = '0;
    end
    bank_model = 1'b0;
    cursor_model = '0;
    count_model = '0;
    period_model = PERIOD_RESET;
    phase_plan = '{16'hFFFF, 16'd5, 16'd1, 16'd0, 16'd2, 16'd3, 16'd0};
    phase_plan[6] = period_t'($urandom_range(4, 12));

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].index,
                directed_rows[i].hold, directed_rows[i].typed, directed_rows[i].reply);
    end

    foreach (phase_plan[p]) begin
      set_swap_period(phase_plan[p]);
      run_random_phase(PHASE_WORDS);
    end

    set_swap_period(period_t'($urandom_range(1, 6)));
    run_random_phase(60);

    drain_and_park();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
